// ----- hw/rtl/qrpt_pkg.sv -----
// ----------------------------------------------------------------------------
// qrpt_pkg
// Shared widths, register indexes and helpers for the quaternion rigid
// point transform.
// ----------------------------------------------------------------------------
package qrpt_pkg;

    // Field widths.
    localparam int QUAT_W  = 16;   // Q1.14 quaternion component
    localparam int COORD_W = 32;   // Q16.16 coordinate
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 32;   // product of two clamped components
    localparam int MAT_W   = 31;   // matrix entry in Q.27
    localparam int MFRAC   = 27;
    localparam int ACC_W   = 64;
    localparam int QRND_W  = ACC_W - MFRAC;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 3 * COORD_W;

    // Configuration register indexes.
    localparam logic [ADDR_W-1:0] CFG_QUAT_W  = 3'd0;
    localparam logic [ADDR_W-1:0] CFG_QUAT_X  = 3'd1;
    localparam logic [ADDR_W-1:0] CFG_QUAT_Y  = 3'd2;
    localparam logic [ADDR_W-1:0] CFG_QUAT_Z  = 3'd3;
    localparam logic [ADDR_W-1:0] CFG_SHIFT_X = 3'd4;
    localparam logic [ADDR_W-1:0] CFG_SHIFT_Y = 3'd5;
    localparam logic [ADDR_W-1:0] CFG_SHIFT_Z = 3'd6;

    // Constants.
    localparam logic signed [QUAT_W-1:0]  Q_ONE     = 16'sd16384;
    localparam logic signed [QUAT_W-1:0]  Q_NEG_ONE = -16'sd16384;
    localparam logic signed [PROD_W-1:0]  M_ONE     = 32'sh0800_0000;
    localparam logic signed [COORD_W-1:0] C_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] C_MIN     = 32'sh8000_0000;
    localparam logic signed [ACC_W-1:0]   RND_HALF  = 64'sd1 <<< (MFRAC - 1);

    // Types.
    typedef logic signed [QUAT_W-1:0]  t_quat;
    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [PROD_W-1:0]  t_qprod;
    typedef logic signed [MAT_W-1:0]   t_coef;
    typedef logic signed [ACC_W-1:0]   t_acc;

    // Clamp a quaternion component to plus or minus one.
    function automatic t_quat clamp_q(input t_quat v);
        t_quat r;
        if (v > Q_ONE) begin
            r = Q_ONE;
        end else if (v < Q_NEG_ONE) begin
            r = Q_NEG_ONE;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/quaternion_rigid_point_transform.sv -----
// ----------------------------------------------------------------------------
// quaternion_rigid_point_transform
// Rotates and translates Q16.16 points with a quaternion-derived matrix.
// ----------------------------------------------------------------------------
// Accepts one point per clock while the result side does not stall and
// passes each point through the pipeline: input register, operand select and
// subtract, nine 31x33 multipliers, three-way sum with translation and
// rounding offset, then round and saturate. The rotation matrix is rebuilt
// from the quaternion registers by a free-running two-stage unit (clamp and
// products, then sums); its output is read by the multiplier stage, which a
// point reaches no earlier than the matrix settles after a register write,
// so a point may follow a configuration write in the next cycle. Command 0
// gives R*p + t, command 1 gives R^T*(p - t). A stall on the result side
// holds every occupied stage in place while empty stages ahead of it still
// fill, so up to five points are held before the input stalls.
module quaternion_rigid_point_transform (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration write port.
    input  logic                       i_cfg_we,
    input  logic [qrpt_pkg::ADDR_W-1:0] i_cfg_addr,
    input  logic [qrpt_pkg::COORD_W-1:0] i_cfg_wdata,
    // Input points.
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [qrpt_pkg::DATA_W-1:0] i_s_axis_tdata,  // point_x, point_y, point_z
    input  logic                       i_s_axis_tuser,  // command
    // Output points.
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [qrpt_pkg::DATA_W-1:0] o_m_axis_tdata,  // out_x, out_y, out_z
    output logic                       o_m_axis_tuser   // saturated
);
    import qrpt_pkg::*;

    // Configuration registers.
    t_quat  r_qw, r_qx, r_qy, r_qz;
    t_coord r_shift [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qw       <= Q_ONE;
            r_qx       <= '0;
            r_qy       <= '0;
            r_qz       <= '0;
            r_shift[0] <= '0;
            r_shift[1] <= '0;
            r_shift[2] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_QUAT_W:  r_qw       <= t_quat'(i_cfg_wdata[QUAT_W-1:0]);
                CFG_QUAT_X:  r_qx       <= t_quat'(i_cfg_wdata[QUAT_W-1:0]);
                CFG_QUAT_Y:  r_qy       <= t_quat'(i_cfg_wdata[QUAT_W-1:0]);
                CFG_QUAT_Z:  r_qz       <= t_quat'(i_cfg_wdata[QUAT_W-1:0]);
                CFG_SHIFT_X: r_shift[0] <= t_coord'(i_cfg_wdata);
                CFG_SHIFT_Y: r_shift[1] <= t_coord'(i_cfg_wdata);
                CFG_SHIFT_Z: r_shift[2] <= t_coord'(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    // Matrix unit, first step: clamp the components and form the products.
    t_quat  w_cw, w_cx, w_cy, w_cz;
    t_qprod r_pxx, r_pyy, r_pzz, r_pxy, r_pxz, r_pyz, r_pxw, r_pyw, r_pzw;

    assign w_cw = clamp_q(r_qw);
    assign w_cx = clamp_q(r_qx);
    assign w_cy = clamp_q(r_qy);
    assign w_cz = clamp_q(r_qz);

    always_ff @(posedge i_clk) begin
        r_pxx <= t_qprod'(w_cx) * t_qprod'(w_cx);
        r_pyy <= t_qprod'(w_cy) * t_qprod'(w_cy);
        r_pzz <= t_qprod'(w_cz) * t_qprod'(w_cz);
        r_pxy <= t_qprod'(w_cx) * t_qprod'(w_cy);
        r_pxz <= t_qprod'(w_cx) * t_qprod'(w_cz);
        r_pyz <= t_qprod'(w_cy) * t_qprod'(w_cz);
        r_pxw <= t_qprod'(w_cx) * t_qprod'(w_cw);
        r_pyw <= t_qprod'(w_cy) * t_qprod'(w_cw);
        r_pzw <= t_qprod'(w_cz) * t_qprod'(w_cw);
    end

    // Matrix unit, second step: entries in Q.27.
    t_coef r_m [3][3];

    always_ff @(posedge i_clk) begin
        r_m[0][0] <= t_coef'(M_ONE - (r_pyy + r_pzz));
        r_m[0][1] <= t_coef'(r_pxy + r_pzw);
        r_m[0][2] <= t_coef'(r_pxz - r_pyw);
        r_m[1][0] <= t_coef'(r_pxy - r_pzw);
        r_m[1][1] <= t_coef'(M_ONE - (r_pxx + r_pzz));
        r_m[1][2] <= t_coef'(r_pyz + r_pxw);
        r_m[2][0] <= t_coef'(r_pxz + r_pyw);
        r_m[2][1] <= t_coef'(r_pyz - r_pxw);
        r_m[2][2] <= t_coef'(M_ONE - (r_pxx + r_pyy));
    end

    // Pipeline flow control: a stage moves when the one after it has room.
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_rdy2, w_rdy3, w_rdy4, w_rdy5;

    assign w_rdy5          = !r_v5 || i_m_axis_tready;
    assign w_rdy4          = !r_v4 || w_rdy5;
    assign w_rdy3          = !r_v3 || w_rdy4;
    assign w_rdy2          = !r_v2 || w_rdy3;
    assign o_s_axis_tready = !r_v1 || w_rdy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_v1 <= i_s_axis_tvalid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
            if (w_rdy5) begin
                r_v5 <= r_v4;
            end
        end
    end

    // Stage 1: capture the point and the command.
    t_coord r_s1_p [3];
    logic   r_s1_inv;

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_s1_p[0] <= t_coord'(i_s_axis_tdata[COORD_W-1:0]);
            r_s1_p[1] <= t_coord'(i_s_axis_tdata[2*COORD_W-1:COORD_W]);
            r_s1_p[2] <= t_coord'(i_s_axis_tdata[3*COORD_W-1:2*COORD_W]);
            r_s1_inv  <= i_s_axis_tuser;
        end
    end

    // Stage 2: operand is the point, or the point less the translation.
    t_diff r_s2_op [3];
    logic  r_s2_inv;

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            for (int j = 0; j < 3; j++) begin
                if (r_s1_inv) begin
                    r_s2_op[j] <= t_diff'(r_s1_p[j]) - t_diff'(r_shift[j]);
                end else begin
                    r_s2_op[j] <= t_diff'(r_s1_p[j]);
                end
            end
            r_s2_inv <= r_s1_inv;
        end
    end

    // Stage 3: nine products, matrix transposed for the inverse command.
    t_acc r_s3_prod [3][3];
    logic r_s3_inv;

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_s3_prod[i][j] <= (r_s2_inv ? r_m[j][i] : r_m[i][j]) * r_s2_op[j];
                end
            end
            r_s3_inv <= r_s2_inv;
        end
    end

    // Stage 4: sum the row, add translation (forward only) and half an LSB.
    t_acc r_s4_acc [3];

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            for (int i = 0; i < 3; i++) begin
                r_s4_acc[i] <= r_s3_prod[i][0] + r_s3_prod[i][1] + r_s3_prod[i][2]
                             + (r_s3_inv ? t_acc'(0) : (t_acc'(r_shift[i]) <<< MFRAC))
                             + RND_HALF;
            end
        end
    end

    // Stage 5: drop the fraction bits and saturate to 32 bits.
    logic [QRND_W-1:0] w_q [3];
    t_coord            w_res [3];
    logic [2:0]        w_clip;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_q[i] = r_s4_acc[i][ACC_W-1:MFRAC];
            if (!w_q[i][QRND_W-1] && (w_q[i][QRND_W-2:COORD_W-1] != '0)) begin
                w_res[i]  = C_MAX;
                w_clip[i] = 1'b1;
            end else if (w_q[i][QRND_W-1] && (w_q[i][QRND_W-2:COORD_W-1] != '1)) begin
                w_res[i]  = C_MIN;
                w_clip[i] = 1'b1;
            end else begin
                w_res[i]  = t_coord'(w_q[i][COORD_W-1:0]);
                w_clip[i] = 1'b0;
            end
        end
    end

    t_coord r_out [3];
    logic   r_sat;

    always_ff @(posedge i_clk) begin
        if (w_rdy5) begin
            r_out[0] <= w_res[0];
            r_out[1] <= w_res[1];
            r_out[2] <= w_res[2];
            r_sat    <= |w_clip;
        end
    end

    assign o_m_axis_tvalid = r_v5;
    assign o_m_axis_tdata  = {r_out[2], r_out[1], r_out[0]};
    assign o_m_axis_tuser  = r_sat;

endmodule

// ----- hw/rtl/qrpt_checker.sv -----
// ----------------------------------------------------------------------------
// qrpt_checker
// Port-level checks for the quaternion rigid point transform.
// ----------------------------------------------------------------------------
module qrpt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_s_axis_tready,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [qrpt_pkg::DATA_W-1:0] o_m_axis_tdata,
    input logic                        o_m_axis_tuser
);
    import qrpt_pkg::*;

    // A stalled output transaction holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output transaction changed while stalled");

    // With the result side ready, the whole pipeline can move, so input is taken.
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tready |-> o_s_axis_tready)
        else $error("input not ready while output side is ready");

    // The clipping flag is only raised when some component sits at a limit.
    a_sat_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |->
            (o_m_axis_tdata[COORD_W-1:0] == C_MAX)
         || (o_m_axis_tdata[COORD_W-1:0] == C_MIN)
         || (o_m_axis_tdata[2*COORD_W-1:COORD_W] == C_MAX)
         || (o_m_axis_tdata[2*COORD_W-1:COORD_W] == C_MIN)
         || (o_m_axis_tdata[3*COORD_W-1:2*COORD_W] == C_MAX)
         || (o_m_axis_tdata[3*COORD_W-1:2*COORD_W] == C_MIN))
        else $error("saturated flag without a clipped component");

    // Reset empties the pipeline.
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind quaternion_rigid_point_transform qrpt_checker u_qrpt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// ----- tb/quaternion_rigid_point_transform_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_rigid_point_transform_tb
// Self-checking bench for the quaternion rigid point transform. A directed
// table covers the identity after reset, extreme points, saturation, the
// 33-bit inverse difference and clamped quaternions. Random phases follow,
// each under a fresh register setting. Every result is compared field by
// field with a table value or one computed in wide exact arithmetic. Both stream
// sides idle at random, and one phase holds the output off for a long stretch.
// ----------------------------------------------------------------------------
module quaternion_rigid_point_transform_tb;
    import qrpt_pkg::*;

    typedef enum logic {
        CMD_FORWARD = 1'b0,
        CMD_INVERSE = 1'b1
    } t_cmd;

    // Register index that decodes to nothing.
    localparam logic [ADDR_W-1:0] CFG_NONE = 3'd7;

    // Register settings used by the directed table.
    localparam logic [1:0] SET_RESET   = 2'd0;
    localparam logic [1:0] SET_FLIP_X  = 2'd1;
    localparam logic [1:0] SET_CLAMPED = 2'd2;
    localparam logic [1:0] SET_TURN_Z  = 2'd3;

    localparam int RAND_PHASES      = 12;
    localparam int PHASE_ITEMS      = 70;
    localparam int LONG_HOLD_PHASE  = 4;
    localparam int CALM_PHASE       = 10;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int IDLE_SETTLE      = 8;

    typedef logic signed [79:0] t_wide;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
        logic   sat;
    } t_point;

    typedef struct packed {
        logic [1:0] setting;
        t_cmd       cmd;
        t_coord     px;
        t_coord     py;
        t_coord     pz;
        logic       has_want;
        t_point     want;
    } t_stim_row;

    // Block inputs start at known values.
    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_cfg_we        = 1'b0;
    logic [ADDR_W-1:0]   i_cfg_addr      = '0;
    logic [COORD_W-1:0]  i_cfg_wdata     = '0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [DATA_W-1:0]   i_s_axis_tdata  = '0;
    logic                i_s_axis_tuser  = 1'b0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [DATA_W-1:0]   o_m_axis_tdata;
    logic                o_m_axis_tuser;

    // Shadow copy of the configuration registers.
    t_quat  quat_reg [0:3];
    t_coord shift_reg [0:2];

    t_point    expected_points [$];
    t_stim_row directed_rows [$];
    int        mismatch_count = 0;
    bit        long_hold_req  = 1'b0;
    bit        calm           = 1'b0;
    bit        sender_gaps    = 1'b1;

    quaternion_rigid_point_transform u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // point_x, point_y, point_z
        .i_s_axis_tuser  (i_s_axis_tuser),   // command
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // out_x, out_y, out_z
        .o_m_axis_tuser  (o_m_axis_tuser)    // saturated
    );

    // Clock generation.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Clamp a quaternion component to plus or minus one and widen it.
    function automatic t_wide limit_quat(input t_quat v);
        if (v > Q_ONE) return t_wide'(Q_ONE);
        if (v < Q_NEG_ONE) return t_wide'(Q_NEG_ONE);
        return t_wide'(v);
    endfunction

    // Rigid transform of one point under the shadow registers.
    function automatic t_point transform_point(input t_cmd cmd, input t_coord px,
                                               input t_coord py, input t_coord pz);
        t_wide  w, x, y, z, one, acc, rnd;
        t_wide  m [0:8];
        t_wide  p [0:2];
        t_wide  t [0:2];
        t_wide  d [0:2];
        t_coord res_c [0:2];
        logic   clip;
        t_point res;
        int     i;
        w = limit_quat(quat_reg[0]);
        x = limit_quat(quat_reg[1]);
        y = limit_quat(quat_reg[2]);
        z = limit_quat(quat_reg[3]);
        one = t_wide'(1) <<< MFRAC;
        m[0] = one - (y * y + z * z);
        m[1] = x * y + z * w;
        m[2] = x * z - y * w;
        m[3] = x * y - z * w;
        m[4] = one - (x * x + z * z);
        m[5] = y * z + x * w;
        m[6] = x * z + y * w;
        m[7] = y * z - x * w;
        m[8] = one - (x * x + y * y);
        p[0] = t_wide'(px);
        p[1] = t_wide'(py);
        p[2] = t_wide'(pz);
        t[0] = t_wide'(shift_reg[0]);
        t[1] = t_wide'(shift_reg[1]);
        t[2] = t_wide'(shift_reg[2]);
        clip = 1'b0;
        for (i = 0; i < 3; i++) begin
            d[i] = p[i] - t[i];
        end
        for (i = 0; i < 3; i++) begin
            if (cmd == CMD_FORWARD) begin
                acc = m[3*i] * p[0] + m[3*i+1] * p[1] + m[3*i+2] * p[2] + t[i] * one;
            end else begin
                acc = m[i] * d[0] + m[3+i] * d[1] + m[6+i] * d[2];
            end
            // Round half up, then clip to 32 bits.
            rnd = (acc + (one >>> 1)) >>> MFRAC;
            if (rnd > t_wide'(C_MAX)) begin
                res_c[i] = C_MAX;
                clip = 1'b1;
            end else if (rnd < t_wide'(C_MIN)) begin
                res_c[i] = C_MIN;
                clip = 1'b1;
            end else begin
                res_c[i] = rnd[COORD_W-1:0];
            end
        end
        res.x = res_c[0];
        res.y = res_c[1];
        res.z = res_c[2];
        res.sat = clip;
        return res;
    endfunction

    // Random coordinate: full range, extremes, or values of moderate size.
    function automatic t_coord rand_coord();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 4))
                    0: return C_MAX;
                    1: return C_MIN;
                    2: return 0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            2: return $signed($urandom) >>> $urandom_range(8, 20);
            default: return $signed($urandom) >>> $urandom_range(1, 7);
        endcase
    endfunction

    // Random quaternion register word; the upper half carries noise.
    function automatic logic [31:0] rand_quat_word(input int mode);
        logic [31:0] noise;
        logic [15:0] lo;
        noise = $urandom;
        case (mode)
            0: lo = 16'($urandom_range(0, 32768) - 16384);
            1: lo = noise[15:0];
            2: begin
                case ($urandom_range(0, 4))
                    0: lo = Q_ONE;
                    1: lo = Q_NEG_ONE;
                    2: lo = 16'h0000;
                    3: lo = 16'h7FFF;
                    default: lo = 16'h8000;
                endcase
            end
            default: lo = 16'($urandom_range(0, 2000) - 1000);
        endcase
        return {noise[31:16], lo};
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    endtask

    // One register write transaction; the shadow copy follows.
    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        case (addr)
            CFG_QUAT_W:  quat_reg[0]  = data[15:0];
            CFG_QUAT_X:  quat_reg[1]  = data[15:0];
            CFG_QUAT_Y:  quat_reg[2]  = data[15:0];
            CFG_QUAT_Z:  quat_reg[3]  = data[15:0];
            CFG_SHIFT_X: shift_reg[0] = data;
            CFG_SHIFT_Y: shift_reg[1] = data;
            CFG_SHIFT_Z: shift_reg[2] = data;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all(input logic [31:0] qw, input logic [31:0] qx,
                             input logic [31:0] qy, input logic [31:0] qz,
                             input t_coord sx, input t_coord sy, input t_coord sz);
        write_reg(CFG_QUAT_W, qw);
        write_reg(CFG_QUAT_X, qx);
        write_reg(CFG_QUAT_Y, qy);
        write_reg(CFG_QUAT_Z, qz);
        write_reg(CFG_SHIFT_X, sx);
        write_reg(CFG_SHIFT_Y, sy);
        write_reg(CFG_SHIFT_Z, sz);
    endtask

    // Fixed settings of the directed table.
    task automatic load_setting(input logic [1:0] sel);
        case (sel)
            SET_FLIP_X: write_all(32'h0000_0000, 32'(Q_ONE), 32'h0, 32'h0,
                                  C_MAX, C_MIN, 32'h0001_0000);
            SET_CLAMPED: begin
                write_all(32'hA5A5_7FFF, 32'hFFFF_8000, 32'h5A5A_4000, 32'h0000_BFFF,
                          C_MIN, C_MAX, 32'h0);
                write_reg(CFG_NONE, 32'hFFFF_FFFF);
            end
            SET_TURN_Z: write_all(32'd11585, 32'h0, 32'h0, 32'd11585,
                                  32'h0001_8000, 32'hFFFE_0000, 32'h7FFF_0000);
            default: ;
        endcase
    endtask

    // Random setting for one phase of the random part.
    task automatic load_random_setting();
        int qmode;
        qmode = $urandom_range(0, 3);
        write_all(rand_quat_word(qmode), rand_quat_word(qmode), rand_quat_word(qmode),
                  rand_quat_word(qmode), rand_coord(), rand_coord(), rand_coord());
        if ($urandom_range(0, 1) == 1) begin
            write_reg(CFG_NONE, $urandom);
        end
    endtask

    task automatic add_row(input logic [1:0] setting, input t_cmd cmd, input t_coord px,
                           input t_coord py, input t_coord pz, input int has_want,
                           input t_coord wx, input t_coord wy, input t_coord wz,
                           input int wsat);
        t_stim_row row;
        row.setting  = setting;
        row.cmd      = cmd;
        row.px       = px;
        row.py       = py;
        row.pz       = pz;
        row.has_want = (has_want != 0);
        row.want     = '{x: wx, y: wy, z: wz, sat: (wsat != 0)};
        directed_rows.push_back(row);
    endtask

    // Offer one point, wait for its transaction, then record the expectation.
    task automatic send_point(input t_cmd cmd, input t_coord px, input t_coord py,
                              input t_coord pz, input logic has_want, input t_point want);
        int gap;
        gap = 0;
        if (sender_gaps && !calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
        end
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= {$urandom, $urandom, $urandom};
            i_s_axis_tuser  <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {pz, py, px};
        i_s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_points.push_back(has_want ? want : transform_point(cmd, px, py, pz));
    endtask

    // Stop offering and let every outstanding result come back.
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    // Result side: random back-pressure, one long hold-off on request.
    initial begin : result_sink
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                i_m_axis_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                long_hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_point want_pt;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_points.size() == 0) begin
                report_mismatch("result with no expectation", o_m_axis_tdata[31:0], 32'h0);
            end else begin
                want_pt = expected_points.pop_front();
                if (o_m_axis_tdata[31:0] !== want_pt.x)
                    report_mismatch("out_x", o_m_axis_tdata[31:0], want_pt.x);
                if (o_m_axis_tdata[63:32] !== want_pt.y)
                    report_mismatch("out_y", o_m_axis_tdata[63:32], want_pt.y);
                if (o_m_axis_tdata[95:64] !== want_pt.z)
                    report_mismatch("out_z", o_m_axis_tdata[95:64], want_pt.z);
                if (o_m_axis_tuser !== want_pt.sat)
                    report_mismatch("saturated", 32'(o_m_axis_tuser), 32'(want_pt.sat));
            end
        end
    end

    // Run limit, far above the slowest correct run.
    initial begin : run_limit
        #5_000_000;
        $display("** quaternion_rigid_point_transform: FAILED **");
        $finish;
    end

    // Main sequence.
    initial begin : stimulus
        t_stim_row  row;
        logic [1:0] cur_setting;
        int         ph;

        quat_reg[0] = Q_ONE;
        quat_reg[1] = '0;
        quat_reg[2] = '0;
        quat_reg[3] = '0;
        shift_reg[0] = '0;
        shift_reg[1] = '0;
        shift_reg[2] = '0;

        // Identity after reset: each point comes back unchanged.
        add_row(SET_RESET, CMD_FORWARD, 0, 0, 0, 1, 0, 0, 0, 0);
        add_row(SET_RESET, CMD_FORWARD, C_MAX, C_MIN, 1, 1, C_MAX, C_MIN, 1, 0);
        add_row(SET_RESET, CMD_INVERSE, C_MIN, C_MAX, -1, 1, C_MIN, C_MAX, -1, 0);
        add_row(SET_RESET, CMD_FORWARD, 32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678,
                1, 32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678, 0);
        add_row(SET_RESET, CMD_INVERSE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
                1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 0);
        // Half turn about x with extreme shifts: saturation both ways and the
        // full 33-bit difference on the inverse path.
        add_row(SET_FLIP_X, CMD_FORWARD, C_MAX, 0, 0, 1, C_MAX, C_MIN, 32'h0001_0000, 1);
        add_row(SET_FLIP_X, CMD_INVERSE, C_MIN, C_MAX, 0, 1, C_MIN, C_MIN, 32'h0001_0000, 1);
        add_row(SET_FLIP_X, CMD_FORWARD, 0, 0, 0, 1, C_MAX, C_MIN, 32'h0001_0000, 0);
        add_row(SET_FLIP_X, CMD_INVERSE, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(SET_FLIP_X, CMD_FORWARD, 32'hFFFF_8000, C_MAX, C_MIN, 0, 0, 0, 0, 0);
        // Quaternion components beyond one, not of unit length.
        add_row(SET_CLAMPED, CMD_FORWARD, C_MAX, C_MAX, C_MAX, 0, 0, 0, 0, 0);
        add_row(SET_CLAMPED, CMD_INVERSE, C_MIN, C_MIN, C_MIN, 0, 0, 0, 0, 0);
        add_row(SET_CLAMPED, CMD_FORWARD, 32'h0000_0001, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
        add_row(SET_CLAMPED, CMD_INVERSE, C_MAX, C_MIN, C_MAX, 0, 0, 0, 0, 0);
        add_row(SET_CLAMPED, CMD_FORWARD, 32'h0003_8000, 32'hFFFC_8000, 32'h0000_4000,
                0, 0, 0, 0, 0);
        add_row(SET_CLAMPED, CMD_INVERSE, 0, 0, 0, 0, 0, 0, 0, 0);
        // Quarter turn about z with an inexact matrix, so rounding shows.
        add_row(SET_TURN_Z, CMD_FORWARD, 32'h0001_0000, 0, 0, 0, 0, 0, 0, 0);
        add_row(SET_TURN_Z, CMD_INVERSE, 32'h0001_0000, 0, 0, 0, 0, 0, 0, 0);
        add_row(SET_TURN_Z, CMD_FORWARD, C_MAX, C_MIN, C_MAX, 0, 0, 0, 0, 0);
        add_row(SET_TURN_Z, CMD_INVERSE, C_MIN, C_MAX, C_MIN, 0, 0, 0, 0, 0);
        add_row(SET_TURN_Z, CMD_FORWARD, 32'h0000_0003, 32'hFFFF_FFFD, 32'h8000_0001,
                0, 0, 0, 0, 0);
        add_row(SET_TURN_Z, CMD_INVERSE, 32'h7FFF_8000, 32'h0000_8000, 32'hFFFF_FFFF,
                0, 0, 0, 0, 0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed table.
        cur_setting = SET_RESET;
        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.setting != cur_setting) begin
                wait_idle();
                load_setting(row.setting);
                cur_setting = row.setting;
            end
            send_point(row.cmd, row.px, row.py, row.pz, row.has_want, row.want);
        end

        // Random phases, each under its own register setting.
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            load_random_setting();
            sender_gaps = (ph != LONG_HOLD_PHASE);
            calm = (ph >= CALM_PHASE);
            if (ph == LONG_HOLD_PHASE) begin
                long_hold_req = 1'b1;
            end
            repeat (PHASE_ITEMS) begin
                send_point(t_cmd'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                           rand_coord(), 1'b0, '0);
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("** quaternion_rigid_point_transform: PASSED **");
        end else begin
            $display("** quaternion_rigid_point_transform: FAILED **");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/qrpt_pkg.sv
hw/rtl/quaternion_rigid_point_transform.sv
hw/rtl/qrpt_checker.sv
tb/quaternion_rigid_point_transform_tb.sv
